// ----- design/mpr_pkg.sv -----
package mpr_pkg;

    // Default parameter values
    localparam int COORD_BITS_DEF    = 12;
    localparam int DECISION_BITS_DEF = 32;

    // Fixed field widths
    localparam int FOCAL_W   = 10;
    localparam int STEP_W    = 13;
    localparam int COUNT_W   = 12;
    localparam int ORIGIN_W  = 12;
    localparam int EXTENT_W  = 13;
    localparam int SCREEN_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    // Input operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X      = 3'd0,
        CFG_ORIGIN_Y      = 3'd1,
        CFG_SCREEN_WIDTH  = 3'd2,
        CFG_SCREEN_HEIGHT = 3'd3,
        CFG_REGION2_STEPS = 3'd4
    } t_cfg_idx;

    // Register reset values
    localparam logic [ORIGIN_W-1:0] ORIGIN_X_RST      = 12'd400;
    localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RST      = 12'd300;
    localparam logic [EXTENT_W-1:0] SCREEN_WIDTH_RST  = 13'd800;
    localparam logic [EXTENT_W-1:0] SCREEN_HEIGHT_RST = 13'd600;
    localparam logic [COUNT_W-1:0]  REGION2_STEPS_RST = 12'd600;

    typedef struct packed {
        logic [ORIGIN_W-1:0] origin_x;
        logic [ORIGIN_W-1:0] origin_y;
        logic [EXTENT_W-1:0] screen_width;
        logic [EXTENT_W-1:0] screen_height;
        logic [COUNT_W-1:0]  region2_steps;
    } t_cfg;

    // Per-item control from the decision engine
    typedef struct packed {
        logic emit;
        logic last;
    } t_emit_ctl;

    // One mirrored pixel pair
    typedef struct packed {
        logic signed [SCREEN_W-1:0] screen_x;
        logic signed [SCREEN_W-1:0] screen_y_minus;
        logic signed [SCREEN_W-1:0] screen_y_plus;
        logic                       minus_off_screen;
        logic                       plus_off_screen;
        logic                       last;
    } t_pair;

endpackage

// ----- design/mpr_if.sv -----
interface mpr_item_if #(
    parameter int COORD_BITS = mpr_pkg::COORD_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic signed [COORD_BITS-1:0]        center_x;
    logic signed [COORD_BITS-1:0]        center_y;
    logic        [mpr_pkg::FOCAL_W-1:0]  focal;

    modport source (output valid, op, center_x, center_y, focal, input ready);
    modport sink   (input valid, op, center_x, center_y, focal, output ready);
endinterface

interface mpr_pair_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mpr_pkg::SCREEN_W-1:0]  screen_x;
    logic signed [mpr_pkg::SCREEN_W-1:0]  screen_y_minus;
    logic signed [mpr_pkg::SCREEN_W-1:0]  screen_y_plus;
    logic                                 minus_off_screen;
    logic                                 plus_off_screen;
    logic                                 last;

    modport source (output valid, screen_x, screen_y_minus, screen_y_plus,
                    minus_off_screen, plus_off_screen, last, input ready);
    modport sink   (input valid, screen_x, screen_y_minus, screen_y_plus,
                    minus_off_screen, plus_off_screen, last, output ready);
endinterface

interface mpr_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [mpr_pkg::CFG_IDX_W-1:0]        index;
    logic [mpr_pkg::CFG_DAT_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/mpr_core.sv -----
module mpr_core #(
    parameter int COORD_BITS    = mpr_pkg::COORD_BITS_DEF,
    parameter int DECISION_BITS = mpr_pkg::DECISION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_process,
    input  logic                                i_op,
    input  logic signed [COORD_BITS-1:0]        i_center_x,
    input  logic signed [COORD_BITS-1:0]        i_center_y,
    input  logic        [mpr_pkg::FOCAL_W-1:0]  i_focal,
    input  logic        [mpr_pkg::COUNT_W-1:0]  i_region2_steps,
    output mpr_pkg::t_emit_ctl                  o_ctl,
    output logic        [mpr_pkg::STEP_W-1:0]   o_step_x,
    output logic        [mpr_pkg::STEP_W-1:0]   o_step_y,
    output logic signed [COORD_BITS-1:0]        o_center_x,
    output logic signed [COORD_BITS-1:0]        o_center_y
);
    import mpr_pkg::*;

    localparam int DB = DECISION_BITS;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_R1,
        PH_R2
    } t_phase;

    t_phase                       r_phase, n_phase;
    logic [STEP_W-1:0]            r_step_x, n_step_x;
    logic [STEP_W-1:0]            r_step_y, n_step_y;
    logic [DB-1:0]                r_dec, n_dec;
    logic [COUNT_W-1:0]           r_left, n_left;
    logic signed [COORD_BITS-1:0] r_cx, n_cx;
    logic signed [COORD_BITS-1:0] r_cy, n_cy;
    logic [FOCAL_W-1:0]           r_focal, n_focal;
    // Running y*y + y and 4a*(x+1), kept for the region 2 entry value
    logic [DB-1:0]                r_sq, n_sq;
    logic [DB-1:0]                r_fx, n_fx;

    logic [DB-1:0]                four_a;
    logic [DB-1:0]                four_a_in;
    logic [STEP_W-1:0]            y_inc;
    logic [DB-1:0]                two_y_inc;
    logic [COUNT_W-1:0]           left_dec;

    assign four_a    = {{(DB-FOCAL_W-2){1'b0}}, r_focal, 2'b00};
    assign four_a_in = {{(DB-FOCAL_W-2){1'b0}}, i_focal, 2'b00};
    assign y_inc     = r_step_y + STEP_W'(1);
    assign two_y_inc = {{(DB-STEP_W-1){1'b0}}, y_inc, 1'b0};
    assign left_dec  = r_left - COUNT_W'(1);

    // Next state for one processed item
    always_comb begin
        n_phase  = r_phase;
        n_step_x = r_step_x;
        n_step_y = r_step_y;
        n_dec    = r_dec;
        n_left   = r_left;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_focal  = r_focal;
        n_sq     = r_sq;
        n_fx     = r_fx;
        o_ctl    = '0;
        if (i_process) begin
            if (i_op == OP_START) begin
                n_cx     = i_center_x;
                n_cy     = i_center_y;
                n_focal  = i_focal;
                n_step_x = '0;
                n_step_y = '0;
                n_sq     = '0;
                n_fx     = four_a_in;
                if (i_focal == '0) begin
                    // Empty region 1: decision y*y+y-4a(x+1) is zero here
                    n_dec  = '0;
                    n_left = i_region2_steps;
                    n_phase = (i_region2_steps == '0) ? PH_IDLE : PH_R2;
                end else begin
                    n_phase = PH_R1;
                    n_left  = {1'b0, i_focal, 1'b0};
                    n_dec   = DB'(1) - {{(DB-FOCAL_W-1){1'b0}}, i_focal, 1'b0};
                end
            end else begin
                unique case (r_phase)
                    PH_R1: begin
                        o_ctl.emit = 1'b1;
                        o_ctl.last = (r_left == COUNT_W'(1)) && (i_region2_steps == '0);
                        n_step_y   = y_inc;
                        n_sq       = r_sq + two_y_inc;
                        if (!r_dec[DB-1]) begin
                            n_step_x = r_step_x + STEP_W'(1);
                            n_fx     = r_fx + four_a;
                            n_dec    = r_dec + two_y_inc + DB'(1) - four_a;
                        end else begin
                            n_dec    = r_dec + two_y_inc + DB'(1);
                        end
                        n_left = left_dec;
                        if (left_dec == '0) begin
                            n_left  = i_region2_steps;
                            n_dec   = n_sq - n_fx;
                            n_phase = (i_region2_steps == '0) ? PH_IDLE : PH_R2;
                        end
                    end
                    PH_R2: begin
                        o_ctl.emit = 1'b1;
                        o_ctl.last = (r_left == COUNT_W'(1));
                        n_step_x   = r_step_x + STEP_W'(1);
                        if (r_dec[DB-1]) begin
                            n_step_y = y_inc;
                            n_dec    = r_dec + two_y_inc - four_a;
                        end else begin
                            n_dec    = r_dec - four_a;
                        end
                        n_left = left_dec;
                        if (left_dec == '0) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        // Idle or finished: drop the step
                    end
                endcase
            end
        end
    end

    // Hold decision state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_step_x <= '0;
            r_step_y <= '0;
            r_dec    <= '0;
            r_left   <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_focal  <= '0;
            r_sq     <= '0;
            r_fx     <= '0;
        end else begin
            r_phase  <= n_phase;
            r_step_x <= n_step_x;
            r_step_y <= n_step_y;
            r_dec    <= n_dec;
            r_left   <= n_left;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_focal  <= n_focal;
            r_sq     <= n_sq;
            r_fx     <= n_fx;
        end
    end

    assign o_step_x   = r_step_x;
    assign o_step_y   = r_step_y;
    assign o_center_x = r_cx;
    assign o_center_y = r_cy;

endmodule

// ----- design/mpr_map.sv -----
module mpr_map #(
    parameter int COORD_BITS = mpr_pkg::COORD_BITS_DEF
) (
    input  mpr_pkg::t_cfg                       i_cfg,
    input  mpr_pkg::t_emit_ctl                  i_ctl,
    input  logic        [mpr_pkg::STEP_W-1:0]   i_step_x,
    input  logic        [mpr_pkg::STEP_W-1:0]   i_step_y,
    input  logic signed [COORD_BITS-1:0]        i_center_x,
    input  logic signed [COORD_BITS-1:0]        i_center_y,
    output mpr_pkg::t_pair                      o_pair
);
    import mpr_pkg::*;

    localparam int SW = ((COORD_BITS > STEP_W) ? COORD_BITS : STEP_W) + 4;

    logic signed [SW-1:0] step_x_s, step_y_s, cx_s, cy_s;
    logic signed [SW-1:0] ox_s, oy_s, wid_s, hgt_s;
    logic signed [SW-1:0] sx, sym, syp;
    logic                 sx_out;

    assign step_x_s = SW'($signed({1'b0, i_step_x}));
    assign step_y_s = SW'($signed({1'b0, i_step_y}));
    assign cx_s     = SW'(i_center_x);
    assign cy_s     = SW'(i_center_y);
    assign ox_s     = SW'($signed({1'b0, i_cfg.origin_x}));
    assign oy_s     = SW'($signed({1'b0, i_cfg.origin_y}));
    assign wid_s    = SW'($signed({1'b0, i_cfg.screen_width}));
    assign hgt_s    = SW'($signed({1'b0, i_cfg.screen_height}));

    // Map user coordinates to screen, flipping rows
    assign sx  = step_x_s + cx_s + ox_s;
    assign sym = hgt_s - (cy_s - step_y_s) - oy_s;
    assign syp = hgt_s - (cy_s + step_y_s) - oy_s;

    // Off-screen tests share the column check
    assign sx_out = sx[SW-1] || (sx > wid_s);

    always_comb begin
        o_pair.screen_x         = sx[SCREEN_W-1:0];
        o_pair.screen_y_minus   = sym[SCREEN_W-1:0];
        o_pair.screen_y_plus    = syp[SCREEN_W-1:0];
        o_pair.minus_off_screen = sx_out || sym[SW-1] || (sym > hgt_s);
        o_pair.plus_off_screen  = sx_out || syp[SW-1] || (syp > hgt_s);
        o_pair.last             = i_ctl.last;
    end

endmodule

// ----- design/midpoint_parabola_rasterizer.sv -----
// Midpoint parabola rasterizer for y^2 = 4ax, opening rightward.
// Channels: i_item takes start (op 0: vertex and focal value) and step (op 1)
// items; o_pair delivers one mirrored pixel pair per step, with off-screen
// flags and a last marker; i_cfg writes the five screen and count registers
// and is always ready. Write configuration only while no item is in flight.
// A step goes through the input register and the output register to o_pair.
// Throughput: one item per cycle unless o_pair stalls; the decision update is
// incremental per pair, and region 2 starts from running sums kept in region 1.
// Start items and steps while idle or past the last pair give no pair.
// Reset (synchronous, active low) restores register defaults and leaves the
// curve idle with no pair pending.
// When o_pair stalls, the pending pair holds and one more item waits in the
// input register; i_item.ready then drops until the pair is taken.
module midpoint_parabola_rasterizer #(
    parameter int COORD_BITS    = mpr_pkg::COORD_BITS_DEF,
    parameter int DECISION_BITS = mpr_pkg::DECISION_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpr_item_if.sink   i_item,
    mpr_cfg_if.sink    i_cfg,
    mpr_pair_if.source o_pair
);
    import mpr_pkg::*;

    t_cfg                         r_cfg;
    logic                         r_in_valid;
    logic                         r_in_op;
    logic signed [COORD_BITS-1:0] r_in_cx;
    logic signed [COORD_BITS-1:0] r_in_cy;
    logic [FOCAL_W-1:0]           r_in_focal;
    logic                         r_out_valid;
    t_pair                        r_out;

    logic                         out_free;
    logic                         process;
    logic                         in_xfer;
    t_emit_ctl                    ctl;
    logic [STEP_W-1:0]            step_x, step_y;
    logic signed [COORD_BITS-1:0] cur_cx, cur_cy;
    t_pair                        pair;

    assign out_free     = !r_out_valid || o_pair.ready;
    assign process      = r_in_valid && out_free;
    assign i_item.ready = !r_in_valid || out_free;
    assign in_xfer      = i_item.valid && i_item.ready;
    assign i_cfg.ready  = 1'b1;

    // Register file writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x      <= ORIGIN_X_RST;
            r_cfg.origin_y      <= ORIGIN_Y_RST;
            r_cfg.screen_width  <= SCREEN_WIDTH_RST;
            r_cfg.screen_height <= SCREEN_HEIGHT_RST;
            r_cfg.region2_steps <= REGION2_STEPS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ORIGIN_X:      r_cfg.origin_x      <= i_cfg.data[ORIGIN_W-1:0];
                CFG_ORIGIN_Y:      r_cfg.origin_y      <= i_cfg.data[ORIGIN_W-1:0];
                CFG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg.data[EXTENT_W-1:0];
                CFG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg.data[EXTENT_W-1:0];
                CFG_REGION2_STEPS: r_cfg.region2_steps <= i_cfg.data[COUNT_W-1:0];
                default: begin
                    // Unknown index: drop the write
                end
            endcase
        end
    end

    // Input register: capture on transfer, release when processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_xfer || (r_in_valid && !process);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_op    <= i_item.op;
            r_in_cx    <= i_item.center_x;
            r_in_cy    <= i_item.center_y;
            r_in_focal <= i_item.focal;
        end
    end

    mpr_core #(
        .COORD_BITS    (COORD_BITS),
        .DECISION_BITS (DECISION_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_process       (process),
        .i_op            (r_in_op),
        .i_center_x      (r_in_cx),
        .i_center_y      (r_in_cy),
        .i_focal         (r_in_focal),
        .i_region2_steps (r_cfg.region2_steps),
        .o_ctl           (ctl),
        .o_step_x        (step_x),
        .o_step_y        (step_y),
        .o_center_x      (cur_cx),
        .o_center_y      (cur_cy)
    );

    mpr_map #(
        .COORD_BITS (COORD_BITS)
    ) u_map (
        .i_cfg      (r_cfg),
        .i_ctl      (ctl),
        .i_step_x   (step_x),
        .i_step_y   (step_y),
        .i_center_x (cur_cx),
        .i_center_y (cur_cy),
        .o_pair     (pair)
    );

    // Output register: load a pair on process, clear on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process) begin
            r_out_valid <= ctl.emit;
        end else if (o_pair.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && ctl.emit) begin
            r_out <= pair;
        end
    end

    assign o_pair.valid            = r_out_valid;
    assign o_pair.screen_x         = r_out.screen_x;
    assign o_pair.screen_y_minus   = r_out.screen_y_minus;
    assign o_pair.screen_y_plus    = r_out.screen_y_plus;
    assign o_pair.minus_off_screen = r_out.minus_off_screen;
    assign o_pair.plus_off_screen  = r_out.plus_off_screen;
    assign o_pair.last             = r_out.last;

endmodule

// ----- design/mpr_checker.sv -----
module mpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_x,
    input logic        i_out_last
);

    // A pending pair stays offered until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("pair dropped while stalled");

    // A stalled pair keeps its screen_x and last marker
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_x) && $stable(i_out_last))
        else $error("pair payload changed while stalled");

    // With no pair pending the input side never blocks
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    // Reset leaves no pair pending
    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("pair pending after reset");

endmodule

bind midpoint_parabola_rasterizer mpr_checker u_mpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_pair.valid),
    .i_out_ready (o_pair.ready),
    .i_out_x     (o_pair.screen_x),
    .i_out_last  (o_pair.last)
);
